// ===== rtl/ssplit_pkg.sv =====
// Shared types, character constants and helpers for the SQL statement splitter.
// Used by the front classifier, the op queue and the back executor.
package ssplit_pkg;

  localparam int unsigned SPACE_DEPTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned N_OPS           = 4;
  localparam int unsigned CHAR_W          = 16;

  localparam logic [CHAR_W-1:0] CH_NL    = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_STAR  = 16'h002A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 16'h002F;
  localparam logic [CHAR_W-1:0] CH_DASH  = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_SQUOT = 16'h0027;
  localparam logic [CHAR_W-1:0] CH_DQUOT = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 16'h003B;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUT,
    OP_FIN
  } op_code_t;

  // One step of work for the back end: put a character or finish a statement.
  typedef struct packed {
    op_code_t          code;
    logic [CHAR_W-1:0] ch;
    logic              space;
  } op_t;

  // Op slots of one input item, in execution order.
  typedef op_t [N_OPS-1:0] entry_t;

  // One result item.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              kind;
    logic              ovf;
  } res_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    logic r;
    r = ((c >= 16'h0009) && (c <= 16'h000D)) ||
        (c == 16'h0020) || (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
        ((c >= 16'h2000) && (c <= 16'h200A)) ||
        (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
        (c == 16'h205F) || (c == 16'h3000);
    return r;
  endfunction

  function automatic op_t put_op(input logic [CHAR_W-1:0] c);
    op_t o;
    o.code  = OP_PUT;
    o.ch    = c;
    o.space = is_space(c);
    return o;
  endfunction

  function automatic op_t fin_op();
    op_t o;
    o.code  = OP_FIN;
    o.ch    = '0;
    o.space = 1'b0;
    return o;
  endfunction

endpackage

// ===== rtl/ssplit_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssplit_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ssplit_front.sv =====
// Front end: accepts code units, tracks quote/comment lexing and the held opener,
// and turns each unit into a queue entry of ops. Uses ssplit_pkg.
module ssplit_front import ssplit_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              q_push,
  output entry_t            q_entry
);

  typedef enum logic [2:0] {
    LX_NORMAL,
    LX_SQUOTE,
    LX_DQUOTE,
    LX_LINE,
    LX_BLOCK
  } lex_t;

  typedef enum logic [1:0] {
    HO_NONE,
    HO_DASH,
    HO_SLASH,
    HO_STAR
  } held_t;

  lex_t   lex_r, lex_nxt;
  held_t  held_r, held_nxt;
  entry_t ent;
  logic   consumed;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign q_entry   = ent;

  always_comb begin
    for (int i = 0; i < N_OPS; i++) begin
      ent[i] = '{code: OP_NONE, ch: '0, space: 1'b0};
    end
    consumed = 1'b0;
    held_nxt = HO_NONE;
    lex_nxt  = lex_r;

    // Resolve the opener held from the previous unit.
    unique case (held_r)
      HO_DASH: begin
        if (in_tdata == CH_DASH) begin
          lex_nxt  = LX_LINE;
          consumed = 1'b1;
        end else begin
          ent[0] = put_op(CH_DASH);
        end
      end
      HO_SLASH: begin
        if (in_tdata == CH_STAR) begin
          lex_nxt  = LX_BLOCK;
          consumed = 1'b1;
        end else begin
          ent[0] = put_op(CH_SLASH);
        end
      end
      HO_STAR: begin
        if (in_tdata == CH_SLASH) begin
          lex_nxt  = LX_NORMAL;
          consumed = 1'b1;
        end
      end
      HO_NONE: ;
    endcase

    if (!consumed) begin
      unique case (lex_r)
        LX_SQUOTE: begin
          ent[1] = put_op(in_tdata);
          if (in_tdata == CH_SQUOT) lex_nxt = LX_NORMAL;
        end
        LX_DQUOTE: begin
          ent[1] = put_op(in_tdata);
          if (in_tdata == CH_DQUOT) lex_nxt = LX_NORMAL;
        end
        LX_LINE: begin
          if (in_tdata == CH_NL) lex_nxt = LX_NORMAL;
        end
        LX_BLOCK: begin
          if (in_tdata == CH_STAR) held_nxt = HO_STAR;
        end
        default: begin
          priority if (in_tdata == CH_DASH) begin
            held_nxt = HO_DASH;
          end else if (in_tdata == CH_SLASH) begin
            held_nxt = HO_SLASH;
          end else if (in_tdata == CH_SQUOT) begin
            ent[1]  = put_op(in_tdata);
            lex_nxt = LX_SQUOTE;
          end else if (in_tdata == CH_DQUOT) begin
            ent[1]  = put_op(in_tdata);
            lex_nxt = LX_DQUOTE;
          end else if (in_tdata == CH_SEMI) begin
            ent[1] = fin_op();
          end else begin
            ent[1] = put_op(in_tdata);
          end
        end
      endcase
    end

    // Script end: release a held '-' or '/', drop a held '*', close the statement.
    if (in_tlast) begin
      if (held_nxt == HO_DASH) begin
        ent[2] = put_op(CH_DASH);
      end else if (held_nxt == HO_SLASH) begin
        ent[2] = put_op(CH_SLASH);
      end
      ent[3]   = fin_op();
      held_nxt = HO_NONE;
      lex_nxt  = LX_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r  <= LX_NORMAL;
      held_r <= HO_NONE;
    end else if (q_push) begin
      lex_r  <= lex_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== rtl/ssplit_queue.sv =====
// Short FIFO of op entries between the front end and the back end.
// Uses ssplit_pkg for the entry type.
module ssplit_queue import ssplit_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == CNT_FULL);
  assign empty     = (cnt_r == '0);
  assign pop_entry = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/ssplit_back.sv =====
// Back end: executes queued ops, trims whitespace through a circular hold buffer
// in RAM and drives the result stream. Uses ssplit_pkg and ssplit_ram.
module ssplit_back import ssplit_pkg::*; #(
  parameter int unsigned SPACE_DEPTH = SPACE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  entry_t            q_entry,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  localparam int unsigned AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SPACE_DEPTH + 1);
  localparam logic [AW-1:0] HEAD_LAST = AW'(SPACE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(SPACE_DEPTH);
  localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(SPACE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_FL_EMIT,
    S_OV_EMIT,
    S_END
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    op_idx_r, op_idx_nxt;
  entry_t        ent_r, ent_nxt;
  logic          started_r, started_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          hold_v_r, hold_v_nxt;
  res_t          hold_r, hold_nxt;
  logic          out_v_r, out_v_nxt;
  res_t          out_r, out_nxt;
  logic          out_last_r, out_last_nxt;

  op_t           cur_op;
  logic          out_free, can_prod, prod, close_run, adv;
  res_t          prod_res;
  logic [AW-1:0] head_inc, tail_addr;
  logic [CW:0]   tail_sum;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  ssplit_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (SPACE_DEPTH)
  ) u_space_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur_op.ch),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_op    = ent_r[op_idx_r];
  assign out_free  = !out_v_r || out_tready;
  assign can_prod  = !hold_v_r || out_free;
  assign head_inc  = (head_r == HEAD_LAST) ? '0 : head_r + AW'(1);
  assign tail_sum  = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign tail_addr = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.ch;
  assign out_tuser  = {out_r.ovf, out_r.kind};
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt   = state_r;
    op_idx_nxt  = op_idx_r;
    ent_nxt     = ent_r;
    started_nxt = started_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tail_addr;
    ram_raddr   = head_r;
    prod        = 1'b0;
    prod_res    = '0;
    close_run   = 1'b0;
    adv         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          ent_nxt    = q_entry;
          op_idx_nxt = '0;
          state_nxt  = S_OP;
        end
      end
      S_OP: begin
        unique case (cur_op.code)
          OP_PUT: begin
            if (cur_op.space) begin
              priority if (!started_r) begin
                adv = 1'b1;
              end else if (count_r == CNT_FULL) begin
                // read the oldest held unit, release it from S_OV_EMIT
                ram_re    = 1'b1;
                state_nxt = S_OV_EMIT;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                adv       = 1'b1;
              end
            end else if (count_r != '0) begin
              ram_re    = 1'b1;
              state_nxt = S_FL_EMIT;
            end else if (can_prod) begin
              prod        = 1'b1;
              prod_res    = '{ch: cur_op.ch, kind: 1'b0, ovf: 1'b0};
              started_nxt = 1'b1;
              adv         = 1'b1;
            end
          end
          OP_FIN: begin
            if (!started_r) begin
              count_nxt = '0;
              adv       = 1'b1;
            end else if (can_prod) begin
              prod        = 1'b1;
              prod_res    = '{ch: '0, kind: 1'b1, ovf: 1'b0};
              started_nxt = 1'b0;
              count_nxt   = '0;
              adv         = 1'b1;
            end
          end
          default: adv = 1'b1;
        endcase
      end
      S_FL_EMIT: begin
        // release held whitespace, oldest first, then go back for the character
        if (can_prod) begin
          prod      = 1'b1;
          prod_res  = '{ch: ram_rdata, kind: 1'b0, ovf: 1'b0};
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
          if (count_r != CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = head_inc;
          end else begin
            state_nxt = S_OP;
          end
        end
      end
      S_OV_EMIT: begin
        if (can_prod) begin
          prod      = 1'b1;
          prod_res  = '{ch: ram_rdata, kind: 1'b0, ovf: 1'b1};
          ram_we    = 1'b1;
          ram_waddr = head_r;
          head_nxt  = head_inc;
          adv       = 1'b1;
        end
      end
      S_END: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          close_run = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (adv) begin
      op_idx_nxt = op_idx_r + 2'd1;
      state_nxt  = (op_idx_r == 2'(N_OPS - 1)) ? S_END : S_OP;
    end

    // One result waits in the hold slot until we know whether another follows.
    out_v_nxt    = out_v_r && !out_tready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    if (prod) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = hold_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = prod_res;
    end
    if (close_run) begin
      out_v_nxt    = 1'b1;
      out_nxt      = hold_r;
      out_last_nxt = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_idx_r  <= '0;
      started_r <= 1'b0;
      head_r    <= '0;
      count_r   <= '0;
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      op_idx_r  <= op_idx_nxt;
      started_r <= started_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      hold_v_r  <= hold_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

endmodule

// ===== rtl/sql_script_statement_splitter.sv =====
// Top level of the SQL script statement splitter: front classifier, op queue,
// back executor with its whitespace hold RAM. Uses ssplit_pkg.
//
// The block reads a script one UTF-16 code unit per transfer (tlast on the final
// unit) and streams out the characters of each statement, each nonempty statement
// closed by a marker result (tuser bit 0 set, tdata zero). Comments are removed,
// quoted text passes through, leading whitespace is dropped and trailing whitespace
// is held in a SPACE_DEPTH-entry RAM; when that fills, the oldest unit is released
// with tuser bit 1 set. tlast on a result marks the last result caused by one input
// unit. The front end takes a unit per cycle into a four-entry queue while the
// queue is not full; the back end steps through each unit (fetch, four op slots,
// close of the run), plus a release step for each whitespace unit released early
// on overflow, plus a hold RAM read start and a release step per unit when a visible
// character flushes held whitespace, and it waits while the result side stalls.
// A unit that yields no result still passes through every one of those steps.
module sql_script_statement_splitter import ssplit_pkg::*; #(
  parameter int unsigned SPACE_DEPTH = SPACE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] char_in
  input  logic        in_tlast,   // script_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] char_out
  output logic [1:0]  out_tuser,  // [0] kind, [1] space_overflow
  output logic        out_tlast   // last_of_run
);

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_in, q_out;

  ssplit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  ssplit_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_out),
    .empty      (q_empty)
  );

  ssplit_back #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
